/* rtl/dsrr_pkg.sv */
package dsrr_pkg;

	localparam int DSRR_MAX_JOBS = 64;

	localparam int JOB_W   = 6;
	localparam int BURST_W = 16;
	localparam int QUANT_W = 8;
	localparam int TICK_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic ACT_ARRIVAL = 1'b0;
	localparam logic ACT_TICK    = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM0   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM1   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_LIMIT = 2'd2;

	localparam logic [QUANT_W-1:0] QUANTUM_RST    = 8'd2;
	localparam logic [TICK_W-1:0]  TICK_LIMIT_RST = 16'hFFFF;

	// controller -> datapath phase strobes
	typedef struct packed {
		logic clear;
		logic arrive;
		logic admit;
		logic tick_start;
		logic pop0;
		logic pop1;
		logic load1;
		logic exec;
		logic push1;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;
		logic halt;
		logic out_free;
	} sts_t;

endpackage

/* rtl/dsrr_ram.sv */
module dsrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/dsrr_ctrl.sv */
module dsrr_ctrl
	import dsrr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic action,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_POP0  = 4'd1;
	localparam logic [3:0] ST_POP1  = 4'd2;
	localparam logic [3:0] ST_LOAD1 = 4'd3;
	localparam logic [3:0] ST_EXEC  = 4'd4;
	localparam logic [3:0] ST_PUSH1 = 4'd5;
	localparam logic [3:0] ST_EMIT  = 4'd6;
	localparam logic [3:0] ST_CLEAR = 4'd7;
	localparam logic [3:0] ST_ARR   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid & ~in_stall;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_TICK) begin
						state_nx = sts.halt ? ST_EMIT : ST_POP0;
					end else begin
						state_nx = ST_ARR;
					end
				end
			end
			ST_ARR:   state_nx = ST_IDLE;
			ST_POP0:  state_nx = ST_POP1;
			ST_POP1:  state_nx = ST_LOAD1;
			ST_LOAD1: state_nx = ST_EXEC;
			ST_EXEC:  state_nx = ST_PUSH1;
			ST_PUSH1: state_nx = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.clear      = (state_q == ST_CLEAR);
		cmd.arrive     = accept & (action == ACT_ARRIVAL);
		cmd.admit      = (state_q == ST_ARR);
		cmd.tick_start = accept & (action == ACT_TICK);
		cmd.pop0       = (state_q == ST_POP0);
		cmd.pop1       = (state_q == ST_POP1);
		cmd.load1      = (state_q == ST_LOAD1);
		cmd.exec       = (state_q == ST_EXEC);
		cmd.push1      = (state_q == ST_PUSH1);
		cmd.emit       = (state_q == ST_EMIT) & sts.out_free;
	end

endmodule

/* rtl/dsrr_dp.sv */
module dsrr_dp
	import dsrr_pkg::*;
#(
	parameter int MAX_JOBS = DSRR_MAX_JOBS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic [JOB_W-1:0]      job_id,
	input  logic [BURST_W-1:0]    burst,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [TICK_W-1:0]     now,
	output logic                  server0_busy,
	output logic [JOB_W-1:0]      server0_job,
	output logic                  server0_first_start,
	output logic                  server0_done,
	output logic                  server1_busy,
	output logic [JOB_W-1:0]      server1_job,
	output logic                  server1_first_start,
	output logic                  server1_done,
	output logic                  halted
);

	localparam int JW = $clog2(MAX_JOBS);
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam logic [JW-1:0] LAST_SLOT = JW'(MAX_JOBS - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_JOBS);

	// job status memory: bit 1 known, bit 0 started
	localparam logic [1:0] JS_ABSENT  = 2'b00;
	localparam logic [1:0] JS_WAITING = 2'b10;
	localparam logic [1:0] JS_STARTED = 2'b11;

	function automatic logic [JW-1:0] ptr_inc(input logic [JW-1:0] p);
		ptr_inc = (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	// configuration
	logic [QUANT_W-1:0] quantum_q [2];
	logic [TICK_W-1:0]  limit_q;

	// queue and job bookkeeping
	logic [JW-1:0]       head_q, tail_q;
	logic [CW-1:0]       count_q;
	logic [JW-1:0]       clr_q;

	// captured arrival
	logic [JOB_W-1:0]   arr_id_q;
	logic [BURST_W-1:0] arr_burst_q;

	// servers
	logic               busy_q  [2];
	logic [JW-1:0]      job_q   [2];
	logic [QUANT_W-1:0] slice_q [2];
	logic [BURST_W-1:0] rem_q   [2];

	// per-tick flags
	logic              popped0_q, popped1_q, pre1_q, halted_q;
	logic              held_q  [2];
	logic              first_q [2];
	logic              done_q  [2];
	logic [TICK_W-1:0] tick_count_q;

	// output register
	logic              out_valid_q;
	logic [TICK_W-1:0] now_q;
	logic              o_busy_q  [2];
	logic [JOB_W-1:0]  o_job_q   [2];
	logic              o_first_q [2];
	logic              o_done_q  [2];
	logic              o_halted_q;

	// memories
	logic               fifo_we, rem_we, st_we;
	logic [JW-1:0]      fifo_wd, fifo_rd, rem_wa, st_wa, st_ra;
	logic [BURST_W-1:0] rem_wd, rem_rd;
	logic [1:0]         st_wd, st_rd;

	// arrival decode
	logic [31:0]   in_wide;
	logic [31:0]   id_wide;
	logic [JW-1:0] id_idx;
	logic          arr_ok;
	logic          not_full;

	// execution
	logic [BURST_W-1:0] rem_cur [2];
	logic [BURST_W-1:0] rem_nx  [2];
	logic [QUANT_W-1:0] q_eff   [2];
	logic               fin     [2];
	logic               pre     [2];
	logic               pop0, pop1;

	assign cfg_ready = 1'b1;

	assign in_wide  = 32'(job_id);
	assign id_wide  = 32'(arr_id_q);
	assign id_idx   = id_wide[JW-1:0];
	assign not_full = (count_q < FULL_CNT);
	assign arr_ok   = (id_wide < 32'(MAX_JOBS)) && (arr_burst_q != '0) && !st_rd[1];

	assign pop0 = cmd.pop0 & ~busy_q[0] & (count_q != '0);
	assign pop1 = cmd.pop1 & ~busy_q[1] & (count_q != '0);

	assign sts.clear_done = (clr_q == LAST_SLOT);
	assign sts.halt       = (tick_count_q >= limit_q);
	assign sts.out_free   = ~out_valid_q | ~out_stall;

	always_comb begin
		rem_cur[0] = rem_q[0];
		rem_cur[1] = popped1_q ? rem_rd : rem_q[1];
		for (int s = 0; s < 2; s++) begin
			q_eff[s]  = (quantum_q[s] == '0) ? QUANT_W'(1) : quantum_q[s];
			rem_nx[s] = (rem_cur[s] != '0) ? rem_cur[s] - 1'b1 : rem_cur[s];
			fin[s]    = busy_q[s] && (rem_nx[s] == '0);
			pre[s]    = busy_q[s] && !fin[s] &&
				(({1'b0, slice_q[s]} + 9'd1) >= {1'b0, q_eff[s]});
		end
	end

	// write ports of the queue and work memories; one source per cycle
	always_comb begin
		fifo_we = 1'b0;
		fifo_wd = id_idx;
		rem_we  = 1'b0;
		rem_wa  = id_idx;
		rem_wd  = arr_burst_q;
		if (cmd.admit && arr_ok) begin
			fifo_we = not_full;
			rem_we  = 1'b1;
		end else if (cmd.exec && pre[0]) begin
			fifo_we = not_full;
			fifo_wd = job_q[0];
			rem_we  = 1'b1;
			rem_wa  = job_q[0];
			rem_wd  = rem_nx[0];
		end else if (cmd.push1 && pre1_q) begin
			fifo_we = not_full;
			fifo_wd = job_q[1];
			rem_we  = 1'b1;
			rem_wa  = job_q[1];
			rem_wd  = rem_q[1];
		end
	end

	// status memory: cleared after reset, looked up at arrival and at each pop
	assign st_ra = cmd.arrive ? in_wide[JW-1:0] : fifo_rd;

	always_comb begin
		st_we = 1'b0;
		st_wa = clr_q;
		st_wd = JS_ABSENT;
		if (cmd.clear) begin
			st_we = 1'b1;
		end else if (cmd.admit && arr_ok) begin
			st_we = 1'b1;
			st_wa = id_idx;
			st_wd = JS_WAITING;
		end else if (cmd.load1 && popped0_q) begin
			st_we = 1'b1;
			st_wa = job_q[0];
			st_wd = JS_STARTED;
		end else if (cmd.exec && popped1_q) begin
			st_we = 1'b1;
			st_wa = job_q[1];
			st_wd = JS_STARTED;
		end
	end

	dsrr_ram #(.WIDTH(JW), .DEPTH(MAX_JOBS)) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (tail_q),
		.wdata (fifo_wd),
		.raddr (head_q),
		.rdata (fifo_rd)
	);

	// work lookup follows the id just read from the queue
	dsrr_ram #(.WIDTH(BURST_W), .DEPTH(MAX_JOBS)) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_wa),
		.wdata (rem_wd),
		.raddr (fifo_rd),
		.rdata (rem_rd)
	);

	dsrr_ram #(.WIDTH(2), .DEPTH(MAX_JOBS)) u_status_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_wa),
		.wdata (st_wd),
		.raddr (st_ra),
		.rdata (st_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q[0] <= QUANTUM_RST;
			quantum_q[1] <= QUANTUM_RST;
			limit_q      <= TICK_LIMIT_RST;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			clr_q        <= '0;
			tick_count_q <= '0;
			popped0_q    <= 1'b0;
			popped1_q    <= 1'b0;
			pre1_q       <= 1'b0;
			halted_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int s = 0; s < 2; s++) begin
				busy_q[s]  <= 1'b0;
				slice_q[s] <= '0;
				held_q[s]  <= 1'b0;
				first_q[s] <= 1'b0;
				done_q[s]  <= 1'b0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_QUANTUM0:   quantum_q[0] <= cfg_data[QUANT_W-1:0];
					REG_QUANTUM1:   quantum_q[1] <= cfg_data[QUANT_W-1:0];
					REG_TICK_LIMIT: limit_q      <= cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end

			if (cmd.clear) begin
				clr_q <= ptr_inc(clr_q);
			end

			if (fifo_we) begin
				tail_q  <= ptr_inc(tail_q);
				count_q <= count_q + 1'b1;
			end

			if (cmd.tick_start) begin
				halted_q  <= sts.halt;
				popped0_q <= 1'b0;
				popped1_q <= 1'b0;
				pre1_q    <= 1'b0;
				for (int s = 0; s < 2; s++) begin
					held_q[s]  <= 1'b0;
					first_q[s] <= 1'b0;
					done_q[s]  <= 1'b0;
				end
			end

			if (pop0) begin
				head_q    <= ptr_inc(head_q);
				count_q   <= count_q - 1'b1;
				popped0_q <= 1'b1;
			end

			if (cmd.pop1 && popped0_q) begin
				busy_q[0]  <= 1'b1;
				slice_q[0] <= '0;
			end

			if (pop1) begin
				head_q    <= ptr_inc(head_q);
				count_q   <= count_q - 1'b1;
				popped1_q <= 1'b1;
			end

			if (cmd.load1 && popped0_q) begin
				first_q[0] <= ~st_rd[0];
			end

			if (cmd.load1 && popped1_q) begin
				busy_q[1]  <= 1'b1;
				slice_q[1] <= '0;
			end

			if (cmd.exec && popped1_q) begin
				first_q[1] <= ~st_rd[0];
			end

			if (cmd.exec) begin
				pre1_q <= pre[1];
				for (int s = 0; s < 2; s++) begin
					held_q[s] <= busy_q[s];
					done_q[s] <= fin[s];
					if (fin[s] || pre[s]) begin
						busy_q[s]  <= 1'b0;
						slice_q[s] <= '0;
					end else if (busy_q[s]) begin
						slice_q[s] <= slice_q[s] + 1'b1;
					end
				end
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (!halted_q) begin
					tick_count_q <= tick_count_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.arrive) begin
			arr_id_q    <= job_id;
			arr_burst_q <= burst;
		end
		if (cmd.pop1 && popped0_q) begin
			job_q[0] <= fifo_rd;
		end
		if (cmd.load1 && popped0_q) begin
			rem_q[0] <= rem_rd;
		end
		if (cmd.load1 && popped1_q) begin
			job_q[1] <= fifo_rd;
		end
		if (cmd.exec) begin
			for (int s = 0; s < 2; s++) begin
				if (busy_q[s]) begin
					rem_q[s] <= rem_nx[s];
				end
			end
		end
		if (cmd.emit) begin
			now_q      <= tick_count_q;
			o_halted_q <= halted_q;
			for (int s = 0; s < 2; s++) begin
				o_busy_q[s]  <= held_q[s];
				o_job_q[s]   <= held_q[s] ? JOB_W'(job_q[s]) : '0;
				o_first_q[s] <= first_q[s];
				o_done_q[s]  <= done_q[s];
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign now                 = now_q;
	assign server0_busy        = o_busy_q[0];
	assign server0_job         = o_job_q[0];
	assign server0_first_start = o_first_q[0];
	assign server0_done        = o_done_q[0];
	assign server1_busy        = o_busy_q[1];
	assign server1_job         = o_job_q[1];
	assign server1_first_start = o_first_q[1];
	assign server1_done        = o_done_q[1];
	assign halted              = o_halted_q;

endmodule

/* rtl/dual_server_round_robin_scheduler.sv */
// Round-robin scheduler for two servers sharing one FIFO ready queue, each
// server with its own quantum (registers 0 and 1) and a halt after tick_limit
// ticks (register 2). After reset the input is stalled while the job status
// memory is cleared. An arrival (action 0) is captured and its job's status
// looked up in the accept cycle, then queued in the arrival state; it gives
// no result. A tick (action 1) runs from the accept cycle through the pop0,
// pop1, load1, exec, push1 and emit states, or straight to emit once the tick
// limit is reached, and waits in emit while a held result is stalled; the
// queue, work and status memories each have a single read and a single write
// port, so the two pops, the look-ups and the two preemption push-backs are
// sequenced one after another. One result is produced per tick; configuration
// is to be written only while the block is idle, which it does not enforce.
module dual_server_round_robin_scheduler
	import dsrr_pkg::*;
#(
	parameter int MAX_JOBS = DSRR_MAX_JOBS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic [JOB_W-1:0]      job_id,
	input  logic [BURST_W-1:0]    burst,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [TICK_W-1:0]     now,
	output logic                  server0_busy,
	output logic [JOB_W-1:0]      server0_job,
	output logic                  server0_first_start,
	output logic                  server0_done,
	output logic                  server1_busy,
	output logic [JOB_W-1:0]      server1_job,
	output logic                  server1_first_start,
	output logic                  server1_done,
	output logic                  halted
);

	cmd_t cmd;
	sts_t sts;

	dsrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dsrr_dp #(.MAX_JOBS(MAX_JOBS)) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.job_id              (job_id),
		.burst               (burst),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.now                 (now),
		.server0_busy        (server0_busy),
		.server0_job         (server0_job),
		.server0_first_start (server0_first_start),
		.server0_done        (server0_done),
		.server1_busy        (server1_busy),
		.server1_job         (server1_job),
		.server1_first_start (server1_first_start),
		.server1_done        (server1_done),
		.halted              (halted)
	);

endmodule

/* sim/dual_server_round_robin_scheduler_test.sv */
module dual_server_round_robin_scheduler_test;
	import dsrr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;	// unmapped, write is dropped
	localparam int QUIET_CYCLES = 16;
	localparam int NJOBS = DSRR_MAX_JOBS;

	typedef struct packed {
		logic [TICK_W-1:0]       now;
		logic [1:0]              busy;
		logic [1:0][JOB_W-1:0]   job;
		logic [1:0]              first;
		logic [1:0]              done;
		logic                    halted;
	} tick_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ACT_ARRIVAL;
	logic [JOB_W-1:0] job_id = '0;
	logic [BURST_W-1:0] burst = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_QUANTUM0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [TICK_W-1:0] now;
	logic server0_busy, server0_first_start, server0_done;
	logic server1_busy, server1_first_start, server1_done;
	logic [JOB_W-1:0] server0_job, server1_job;
	logic halted;

	dual_server_round_robin_scheduler uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .job_id(job_id), .burst(burst),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.now(now),
		.server0_busy(server0_busy), .server0_job(server0_job),
		.server0_first_start(server0_first_start), .server0_done(server0_done),
		.server1_busy(server1_busy), .server1_job(server1_job),
		.server1_first_start(server1_first_start), .server1_done(server1_done),
		.halted(halted)
	);

	always #4 clk = ~clk;

	// scheduler state as predicted
	logic [JOB_W-1:0]   rq_mem [NJOBS];
	logic [JOB_W-1:0]   rq_head;
	logic [JOB_W:0]     rq_count;
	logic [BURST_W-1:0] work_left [NJOBS];
	logic               job_known [NJOBS];
	logic               job_begun [NJOBS];
	logic               srv_busy [2];
	logic [JOB_W-1:0]   srv_job [2];
	logic [QUANT_W-1:0] srv_slice [2];
	logic [TICK_W-1:0]  tick_now;
	logic [QUANT_W-1:0] quantum [2];
	logic [TICK_W-1:0]  limit_ticks;

	tick_report_t pending_reports [$];

	int gap_pct = 0;
	int stall_pct = 0;
	int fails = 0;
	int items_sent = 0;
	int ticks_sent = 0;
	int jobs_admitted = 0;
	int completions = 0;
	int halted_ticks = 0;
	int reports_checked = 0;
	int settings_written = 0;

	function automatic void queue_job(logic [JOB_W-1:0] id);
		if (rq_count < NJOBS) begin
			rq_mem[JOB_W'(rq_head + rq_count[JOB_W-1:0])] = id;
			rq_count = rq_count + 1'b1;
		end
	endfunction

	function automatic void admit_job(logic [JOB_W-1:0] id, logic [BURST_W-1:0] amount);
		if (amount != '0 && !job_known[id]) begin
			job_known[id] = 1'b1;
			work_left[id] = amount;
			job_begun[id] = 1'b0;
			queue_job(id);
			jobs_admitted++;
		end
	endfunction

	function automatic tick_report_t advance_tick();
		tick_report_t r;
		logic [QUANT_W-1:0] q;
		logic [JOB_W-1:0] id;
		r = '0;
		r.now = tick_now;
		if (tick_now >= limit_ticks) begin
			r.halted = 1'b1;
			return r;
		end
		// idle servers take the queue head, server 0 first
		for (int s = 0; s < 2; s++) begin
			if (!srv_busy[s] && rq_count != 0) begin
				id = rq_mem[rq_head];
				rq_head = rq_head + 1'b1;
				rq_count = rq_count - 1'b1;
				srv_busy[s] = 1'b1;
				srv_job[s] = id;
				srv_slice[s] = '0;
				if (!job_begun[id]) begin
					job_begun[id] = 1'b1;
					r.first[s] = 1'b1;
				end
			end
		end
		for (int s = 0; s < 2; s++) begin
			if (srv_busy[s]) begin
				q = (quantum[s] == '0) ? QUANT_W'(1) : quantum[s];
				id = srv_job[s];
				r.busy[s] = 1'b1;
				r.job[s] = id;
				if (work_left[id] != '0)
					work_left[id] = work_left[id] - 1'b1;
				if (work_left[id] == '0) begin
					r.done[s] = 1'b1;
					srv_busy[s] = 1'b0;
					srv_slice[s] = '0;
				end else if (int'(srv_slice[s]) + 1 >= int'(q)) begin
					queue_job(id);
					srv_busy[s] = 1'b0;
					srv_slice[s] = '0;
				end else begin
					srv_slice[s] = srv_slice[s] + 1'b1;
				end
			end
		end
		tick_now = tick_now + 1'b1;
		return r;
	endfunction

	function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_QUANTUM0: begin
				quantum[0] = val[QUANT_W-1:0];
			end
			REG_QUANTUM1: begin
				quantum[1] = val[QUANT_W-1:0];
			end
			REG_TICK_LIMIT: begin
				limit_ticks = val[TICK_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int fresh_job();
		int pool [$];
		for (int i = 0; i < NJOBS; i++)
			if (!job_known[i])
				pool.push_back(i);
		if (pool.size() == 0)
			return -1;
		return pool[$urandom_range(0, pool.size() - 1)];
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	// one transaction on the input channel; valid is left high for a back-to-back follower
	task automatic send_item(logic act, logic [JOB_W-1:0] id, logic [BURST_W-1:0] amount);
		tick_report_t r;
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
		end
		in_valid <= 1'b1;
		action <= act;
		job_id <= id;
		burst <= amount;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (act == ACT_TICK) begin
			r = advance_tick();
			ticks_sent++;
			completions += int'(r.done[0]) + int'(r.done[1]);
			halted_ticks += int'(r.halted);
			pending_reports.push_back(r);
		end else begin
			admit_job(id, amount);
		end
	endtask

	task automatic send_tick();
		send_item(ACT_TICK, JOB_W'($urandom), BURST_W'($urandom));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	task automatic program_regs(logic [CFG_DATA_W-1:0] q0, logic [CFG_DATA_W-1:0] q1,
			logic [CFG_DATA_W-1:0] lim);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [CFG_DATA_W-1:0] vals [4];
		idx = '{REG_QUANTUM0, REG_QUANTUM1, REG_TICK_LIMIT, REG_SPARE};
		vals = '{q0, q1, lim, CFG_DATA_W'($urandom)};
		drain_results();
		// an arrival gives no result, so the block may still be busy
		repeat (QUIET_CYCLES) @(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			store_reg(idx[i], vals[i]);
		end
		cfg_valid <= 1'b0;
		settings_written++;
	endtask

	// mostly ticks with fresh jobs mixed in; ignored arrivals do not count
	task automatic run_traffic(int n_items);
		int sent;
		int pick;
		int id;
		logic [BURST_W-1:0] amount;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			id = fresh_job();
			if (pick < 8) begin
				id = $urandom_range(0, NJOBS - 1);
				amount = job_known[id] ? BURST_W'($urandom) : '0;
				send_item(ACT_ARRIVAL, JOB_W'(id), amount);
			end else if (pick < 13 && id >= 0) begin
				amount = ($urandom_range(0, 4) == 0) ? BURST_W'($urandom_range(9, 300))
					: BURST_W'($urandom_range(1, 8));
				send_item(ACT_ARRIVAL, JOB_W'(id), amount);
				sent++;
			end else begin
				send_tick();
				sent++;
			end
		end
	endtask

	function automatic logic [CFG_DATA_W-1:0] small_quantum();
		return {8'($urandom), 8'($urandom_range(1, 6))};
	endfunction

	task automatic test_directed();
		send_tick();	// both servers idle
		send_item(ACT_ARRIVAL, 6'd0, 16'd0);	// zero burst, dropped
		send_item(ACT_ARRIVAL, 6'd0, 16'd1);
		send_item(ACT_ARRIVAL, 6'd63, 16'd5);
		send_item(ACT_ARRIVAL, 6'd63, 16'd2);	// id already known
		send_item(ACT_ARRIVAL, 6'd42, 16'd3);
		repeat (3) send_tick();
		send_item(ACT_ARRIVAL, 6'd21, 16'hFFFF);
		send_item(ACT_ARRIVAL, 6'd0, 16'd7);	// completed id, still known
		repeat (6) send_tick();
		send_item(ACT_ARRIVAL, 6'd42, 16'hAAAA);
		repeat (4) send_tick();
	endtask

	task automatic test_quantum_extremes();
		// quantum 0 behaves as 1; upper data bits are not part of a quantum
		program_regs(16'hFF00, 16'h00FF, 16'hFFFF);
		gap_pct = 0;
		stall_pct = 0;
		run_traffic(260);
	endtask

	task automatic test_quantum_lowered();
		// jobs deep into a 255-tick slice get cut at the end of the next tick
		program_regs(16'h5A01, 16'h0001, 16'hFFFF);
		gap_pct = 53;
		run_traffic(240);
	endtask

	task automatic test_tick_limit();
		int id;
		gap_pct = 0;
		program_regs(16'd3, 16'd4, CFG_DATA_W'(tick_now + 16'd6));
		repeat (8) send_tick();
		id = fresh_job();
		if (id >= 0)
			send_item(ACT_ARRIVAL, JOB_W'(id), 16'd2);	// taken in while halted
		repeat (2) send_tick();
		program_regs(16'd3, 16'd4, 16'h0000);
		repeat (3) send_tick();
		program_regs(small_quantum(), small_quantum(), 16'hFFFF);
		repeat (6) send_tick();
	endtask

	task automatic test_receiver_stall();
		program_regs(small_quantum(), small_quantum(), 16'($urandom_range(40000, 65534)));
		gap_pct = 0;
		stall_pct = 53;
		run_traffic(260);
	endtask

	task automatic test_both_idle();
		program_regs(16'($urandom_range(1, 255)), small_quantum(), 16'hFFFF);
		gap_pct = 18;
		stall_pct = 18;
		run_traffic(260);
	endtask

	task automatic test_mixed_pressure();
		program_regs(small_quantum(), 16'($urandom_range(1, 255)), 16'hFFFF);
		gap_pct = 0;
		stall_pct = 0;
		run_traffic(190);
		drain_results();	// hold off until every report is back
		run_traffic(190);
	endtask

	always @(posedge clk)
		out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin : compare_report
		tick_report_t got;
		tick_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.now = now;
			got.busy = {server1_busy, server0_busy};
			got.job = {server1_job, server0_job};
			got.first = {server1_first_start, server0_first_start};
			got.done = {server1_done, server0_done};
			got.halted = halted;
			if (pending_reports.size() == 0) begin
				$error("unexpected result transaction, now %0d", now);
				fails++;
			end else begin
				want = pending_reports.pop_front();
				reports_checked++;
				check_field("now", want.now, got.now);
				for (int s = 0; s < 2; s++) begin
					check_field($sformatf("server%0d_busy", s), want.busy[s], got.busy[s]);
					check_field($sformatf("server%0d_job", s), want.job[s], got.job[s]);
					check_field($sformatf("server%0d_first_start", s),
						want.first[s], got.first[s]);
					check_field($sformatf("server%0d_done", s), want.done[s], got.done[s]);
				end
				check_field("halted", want.halted, got.halted);
			end
		end
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		rq_head = '0;
		rq_count = '0;
		for (int i = 0; i < NJOBS; i++) begin
			job_known[i] = 1'b0;
			job_begun[i] = 1'b0;
		end
		for (int s = 0; s < 2; s++) begin
			srv_busy[s] = 1'b0;
			srv_job[s] = '0;
			srv_slice[s] = '0;
			quantum[s] = QUANTUM_RST;
		end
		tick_now = '0;
		limit_ticks = TICK_LIMIT_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_quantum_extremes();
		test_quantum_lowered();
		test_tick_limit();
		test_receiver_stall();
		test_both_idle();
		test_mixed_pressure();

		drain_results();
		repeat (QUIET_CYCLES) @(posedge clk);
		if (pending_reports.size() != 0) begin
			$error("%0d expected results never arrived", pending_reports.size());
			fails++;
		end
		$display("run: %0d transactions in (%0d ticks, %0d jobs admitted), %0d reports checked",
			items_sent, ticks_sent, jobs_admitted, reports_checked);
		$display("run: %0d completions, %0d halted ticks, %0d register settings",
			completions, halted_ticks, settings_written);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
